@@ rtl/m3i_pkg.sv @@
// shared types, widths and tables for the 3x3 matrix inverse pipeline
package m3i_pkg;

    localparam int EW   = 32;
    localparam int CW   = 2 * EW + 1;
    localparam int DETW = 3 * EW + 1;
    localparam int QW   = 32;
    localparam int RW   = DETW + QW + 1;
    localparam int TW   = 31;
    localparam int NL   = 9;
    localparam int NS   = 9 + QW;

    typedef logic [3:0] idx_t;

    localparam idx_t COF_IDX [NL][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    typedef struct packed {
        logic signed [EW-1:0] a00;
        logic signed [EW-1:0] a01;
        logic signed [EW-1:0] a02;
        logic signed [EW-1:0] a10;
        logic signed [EW-1:0] a11;
        logic signed [EW-1:0] a12;
        logic signed [EW-1:0] a20;
        logic signed [EW-1:0] a21;
        logic signed [EW-1:0] a22;
    } in_t;

    typedef struct packed {
        logic signed [EW-1:0] inv_00;
        logic signed [EW-1:0] inv_01;
        logic signed [EW-1:0] inv_02;
        logic signed [EW-1:0] inv_10;
        logic signed [EW-1:0] inv_11;
        logic signed [EW-1:0] inv_12;
        logic signed [EW-1:0] inv_20;
        logic signed [EW-1:0] inv_21;
        logic signed [EW-1:0] inv_22;
        logic                 singular;
        logic                 saturated;
    } out_t;

endpackage

@@ rtl/m3i_cof_lane.sv @@
// one cofactor lane: two products and their difference
module m3i_cof_lane (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [m3i_pkg::EW-1:0] ep,
    input  logic signed [m3i_pkg::EW-1:0] eq,
    input  logic signed [m3i_pkg::EW-1:0] er,
    input  logic signed [m3i_pkg::EW-1:0] es,
    output logic signed [m3i_pkg::CW-1:0] cof
);
    import m3i_pkg::*;

    logic signed [2*EW-1:0] pa_reg, pb_reg;
    logic signed [CW-1:0]   cof_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg  <= ep * eq;
            pb_reg  <= er * es;
            cof_reg <= CW'(pa_reg) - CW'(pb_reg);
        end
    end

    assign cof = cof_reg;
endmodule

@@ rtl/m3i_det.sv @@
// determinant, its magnitude and the singular test
module m3i_det #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [m3i_pkg::EW-1:0]   e0,
    input  logic signed [m3i_pkg::EW-1:0]   e1,
    input  logic signed [m3i_pkg::EW-1:0]   e2,
    input  logic signed [m3i_pkg::CW-1:0]   c0,
    input  logic signed [m3i_pkg::CW-1:0]   c3,
    input  logic signed [m3i_pkg::CW-1:0]   c6,
    input  logic        [m3i_pkg::TW-1:0]   thr,
    output logic        [m3i_pkg::DETW-1:0] dmag,
    output logic                            dsign,
    output logic                            singular
);
    import m3i_pkg::*;

    localparam int PW = 2 * EW + 1;

    logic signed [EW-1:0]   ed1_reg [3];
    logic signed [EW-1:0]   ed2_reg [3];
    logic signed [PW-1:0]   lo_reg  [3];
    logic signed [PW-1:0]   hi_reg  [3];
    logic signed [CW-1:0]   cin     [3];
    logic signed [DETW-1:0] det_reg;
    logic        [DETW-1:0] dmag_reg;
    logic                   dsign_reg;
    logic        [DETW-1:0] lim;
    logic                   sing_reg [QW+2];

    assign cin[0] = c0;
    assign cin[1] = c3;
    assign cin[2] = c6;
    assign lim    = DETW'(thr) << (2 * FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ed1_reg[0] <= e0;
            ed1_reg[1] <= e1;
            ed1_reg[2] <= e2;
            for (int k = 0; k < 3; k++)
            begin
                ed2_reg[k] <= ed1_reg[k];
                lo_reg[k]  <= ed2_reg[k] * $signed({1'b0, cin[k][EW-1:0]});
                hi_reg[k]  <= ed2_reg[k] * $signed(cin[k][CW-1:EW]);
            end
            det_reg   <= ((DETW'(hi_reg[0]) <<< EW) + DETW'(lo_reg[0]))
                       + ((DETW'(hi_reg[1]) <<< EW) + DETW'(lo_reg[1]))
                       + ((DETW'(hi_reg[2]) <<< EW) + DETW'(lo_reg[2]));
            dmag_reg  <= det_reg[DETW-1] ? DETW'(-det_reg) : DETW'(det_reg);
            dsign_reg <= det_reg[DETW-1];
            sing_reg[0] <= (dmag_reg == '0) || (dmag_reg < lim);
            for (int k = 1; k < QW + 2; k++)
                sing_reg[k] <= sing_reg[k-1];
        end
    end

    assign dmag     = dmag_reg;
    assign dsign    = dsign_reg;
    assign singular = sing_reg[QW+1];
endmodule

@@ rtl/m3i_div_lane.sv @@
// one division lane: rounded numerator and a restoring divider, one quotient bit a stage
module m3i_div_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [m3i_pkg::CW-1:0]   cof,
    input  logic        [m3i_pkg::DETW-1:0] dmag,
    input  logic                            dsign,
    output logic        [m3i_pkg::QW-1:0]   q,
    output logic                            ovf,
    output logic                            neg
);
    import m3i_pkg::*;

    logic [CW-1:0] cabs_reg [3];
    logic          csign_reg [3];
    logic [RW-1:0] n_reg, dn_reg;
    logic          negn_reg;
    logic [RW-1:0] r_reg [QW+1];
    logic [RW-1:0] d_reg [QW+1];
    logic [QW-1:0] q_reg [QW+1];
    logic          ovf_reg [QW+1];
    logic          neg_reg [QW+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cabs_reg[0]  <= cof[CW-1] ? CW'(-cof) : CW'(cof);
            csign_reg[0] <= cof[CW-1];
            for (int k = 1; k < 3; k++)
            begin
                cabs_reg[k]  <= cabs_reg[k-1];
                csign_reg[k] <= csign_reg[k-1];
            end
            n_reg    <= (RW'(cabs_reg[2]) << (2 * FRAC_BITS + 1)) + RW'(dmag);
            dn_reg   <= RW'(dmag) << QW;
            negn_reg <= csign_reg[2] ^ dsign;
            r_reg[0]   <= n_reg;
            d_reg[0]   <= dn_reg;
            q_reg[0]   <= '0;
            ovf_reg[0] <= n_reg >= (dn_reg << 1);
            neg_reg[0] <= negn_reg;
            for (int k = 1; k <= QW; k++)
            begin
                if (r_reg[k-1] >= d_reg[k-1])
                begin
                    r_reg[k] <= (r_reg[k-1] - d_reg[k-1]) << 1;
                    q_reg[k] <= {q_reg[k-1][QW-2:0], 1'b1};
                end
                else
                begin
                    r_reg[k] <= r_reg[k-1] << 1;
                    q_reg[k] <= {q_reg[k-1][QW-2:0], 1'b0};
                end
                d_reg[k]   <= d_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    assign q   = q_reg[QW];
    assign ovf = ovf_reg[QW];
    assign neg = neg_reg[QW];
endmodule

@@ rtl/m3i_merge.sv @@
// merging stage: saturation, sign and singular masking into the output register
module m3i_merge (
    input  logic                        clk,
    input  logic                        en,
    input  logic [m3i_pkg::QW-1:0]      q   [m3i_pkg::NL],
    input  logic                        ovf [m3i_pkg::NL],
    input  logic                        neg [m3i_pkg::NL],
    input  logic                        singular,
    output m3i_pkg::out_t               res
);
    import m3i_pkg::*;

    localparam logic [QW-1:0] POS_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] NEG_MAX = {1'b1, {(QW-1){1'b0}}};

    logic [EW-1:0] val  [NL];
    logic [NL-1:0] clip;
    out_t          res_next, res_reg;

    always_comb
    begin
        for (int k = 0; k < NL; k++)
        begin
            logic [QW-1:0] maxm, mag;
            maxm    = neg[k] ? NEG_MAX : POS_MAX;
            clip[k] = ovf[k] || (q[k] > maxm);
            mag     = clip[k] ? maxm : q[k];
            val[k]  = singular ? '0 : (neg[k] ? EW'(-mag) : EW'(mag));
        end
        res_next.inv_00    = val[0];
        res_next.inv_01    = val[1];
        res_next.inv_02    = val[2];
        res_next.inv_10    = val[3];
        res_next.inv_11    = val[4];
        res_next.inv_12    = val[5];
        res_next.inv_20    = val[6];
        res_next.inv_21    = val[7];
        res_next.inv_22    = val[8];
        res_next.singular  = singular;
        res_next.saturated = !singular && (|clip);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res = res_reg;
endmodule

@@ rtl/matrix3_inverse_top.sv @@
// top level of the pipelined 3x3 matrix inverse
//
//  channel | signals                         | moves
//  in      | in_valid, in_ready, in_data     | one matrix per transaction
//  out     | out_valid, out_ready, out_data  | inverse and flags per transaction
//  cfg     | cfg_valid, cfg_ready, cfg_data  | singular threshold write
//
// one matrix enters every cycle unless a waiting output transaction stalls the pipeline;
// out_valid rises when the accepted matrix reaches the output register
// stages: input register, 2 cofactor, 3 determinant, 1 numerator, 33 divider, output register
// the whole pipeline advances together and holds while the output transaction waits
// reset clears the valid line and sets the threshold to 1; no clearing pass
// cfg_ready is always high
module matrix3_inverse_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  m3i_pkg::in_t           in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output m3i_pkg::out_t          out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [m3i_pkg::TW-1:0] cfg_data
);
    import m3i_pkg::*;

    logic                   en;
    logic [NS-1:0]          v_reg;
    logic [TW-1:0]          thr_reg;
    in_t                    in_reg;
    logic signed [EW-1:0]   e [NL];
    logic signed [CW-1:0]   cof [NL];
    logic [DETW-1:0]        dmag;
    logic                   dsign;
    logic                   singular;
    logic [QW-1:0]          q   [NL];
    logic                   ovf [NL];
    logic                   neg [NL];

    assign en        = !v_reg[NS-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = v_reg[NS-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            thr_reg <= TW'(1);
        end
        else
        begin
            if (en)
                v_reg <= {v_reg[NS-2:0], in_valid};
            if (cfg_valid)
                thr_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            in_reg <= in_data;
    end

    assign e[0] = in_reg.a00;
    assign e[1] = in_reg.a01;
    assign e[2] = in_reg.a02;
    assign e[3] = in_reg.a10;
    assign e[4] = in_reg.a11;
    assign e[5] = in_reg.a12;
    assign e[6] = in_reg.a20;
    assign e[7] = in_reg.a21;
    assign e[8] = in_reg.a22;

    for (genvar k = 0; k < NL; k++)
    begin : g_lane
        m3i_cof_lane u_cof (
            .clk (clk),
            .en  (en),
            .ep  (e[COF_IDX[k][0]]),
            .eq  (e[COF_IDX[k][1]]),
            .er  (e[COF_IDX[k][2]]),
            .es  (e[COF_IDX[k][3]]),
            .cof (cof[k])
        );

        m3i_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div (
            .clk   (clk),
            .en    (en),
            .cof   (cof[k]),
            .dmag  (dmag),
            .dsign (dsign),
            .q     (q[k]),
            .ovf   (ovf[k]),
            .neg   (neg[k])
        );
    end

    m3i_det #(.FRAC_BITS(FRAC_BITS)) u_det (
        .clk      (clk),
        .en       (en),
        .e0       (e[0]),
        .e1       (e[1]),
        .e2       (e[2]),
        .c0       (cof[0]),
        .c3       (cof[3]),
        .c6       (cof[6]),
        .thr      (thr_reg),
        .dmag     (dmag),
        .dsign    (dsign),
        .singular (singular)
    );

    m3i_merge u_merge (
        .clk      (clk),
        .en       (en),
        .q        (q),
        .ovf      (ovf),
        .neg      (neg),
        .singular (singular),
        .res      (out_data)
    );

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.singular |-> !out_data.saturated && out_data.inv_00 == '0
            && out_data.inv_11 == '0 && out_data.inv_22 == '0)
        else $error("singular result carries data");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(v_reg) && $stable(out_data))
        else $error("pipeline moved during stall");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output register");
endmodule
